FILE: design/heightmap_triangle_height_sampler_assert.svh
// Assertion macros for the heightmap triangle height sampler checker
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLER_ASSERT_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLER_ASSERT_SVH

// same-cycle implication, sampled on clk, off in reset
`define HTS_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HTS_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/hts_pkg.sv
// Shared types and constants of the heightmap triangle height sampler
package hts_pkg;

  typedef struct packed {
    logic               command;
    logic [7:0]         vertex_row;
    logic [7:0]         vertex_col;
    logic signed [15:0] vertex_height;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] height_out;
    logic               saturated;
  } out_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_CELL = 2'd2;

  typedef enum logic {UNIT_DIV, UNIT_MUL} unit_op_t;

  // restoring divide: 42 quotient bits; shift-add multiply: 17 multiplier bits
  localparam logic [5:0] DIV_LAST = 6'd41;
  localparam logic [5:0] MUL_LAST = 6'd16;

  typedef struct packed {
    logic               go;
    unit_op_t           op;
    logic [41:0]        num;
    logic [16:0]        den;
    logic signed [44:0] mcand;
    logic signed [16:0] mplier;
    logic signed [63:0] acc_in;
  } unit_req_t;

  typedef struct packed {
    logic               done;
    logic [41:0]        quot;
    logic               rem_nz;
    logic signed [63:0] acc;
  } unit_rsp_t;

endpackage

FILE: design/heightmap_triangle_height_sampler.sv
// Heightmap triangle height sampler, top level with sequencer
// Write beat: busy while in S_WRITE, no result; the next beat can be taken once busy is low.
// Query beat: result strobe after two 42-step divisions and two 17-step multiplies on one
// adder; the next beat can be taken in the strobe cycle.
// One beat at a time: start is taken only while busy is low; results cannot be stalled.
// Synchronous active-low reset restores grid_rows, grid_cols = 256 and cell_size = 256
// (Q8.8 1.0); the height store is not cleared and is undefined until written.
module heightmap_triangle_height_sampler #(
  parameter int MAX_DIM     = 256,
  parameter int HEIGHT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  hts_pkg::in_t  in_data,
  output logic          out_strobe,
  output hts_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  // stored width: never more than the 16 bits of a height
  localparam int HSW    = (HEIGHT_BITS < 16) ? HEIGHT_BITS : 16;
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  // grid registers are 9 bits, so a dimension never exceeds 511
  localparam logic [8:0] DIM_CAP = (MAX_DIM > 511) ? 9'd511 : 9'(MAX_DIM);

  typedef enum logic [4:0] {
    S_IDLE, S_WRITE, S_PREP_X, S_PREP_Z, S_DIV_GO, S_DIV_WAIT, S_QFIX, S_CLAMP,
    S_ADDR, S_RD_A, S_RD_B, S_RD_C, S_RD_D, S_RD_END, S_SETUP,
    S_MUL1_GO, S_MUL1_WAIT, S_MUL2_GO, S_MUL2_WAIT, S_OUT
  } state_t;

  state_t             state_r;
  hts_pkg::in_t       item_r;
  logic [8:0]         rows_r;
  logic [8:0]         cols_r;
  logic [15:0]        cell_r;
  logic               axis_r;     // 0 works on x / columns, 1 on z / rows
  logic signed [26:0] n_r;        // shifted position, 1/512 units
  logic               neg_r;
  logic signed [42:0] q_r;        // floor(n * 65536 / 2s)
  logic [8:0]         col_r;
  logic [8:0]         row_r;
  logic signed [42:0] dx_r;
  logic signed [42:0] dz_r;
  logic [17:0]        addr_r;
  logic signed [16:0] a_r, b_r, c_r, d_r;
  logic signed [44:0] m1_r, m2_r;
  logic signed [16:0] d1_r, d2_r;
  logic signed [63:0] acc0_r;
  logic               out_strobe_r;
  hts_pkg::out_t      out_data_r;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 9'd256;
      cols_r <= 9'd256;
      cell_r <= 16'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hts_pkg::CFG_ROWS: rows_r <= cfg_data[8:0];
        hts_pkg::CFG_COLS: cols_r <= cfg_data[8:0];
        hts_pkg::CFG_CELL: cell_r <= cfg_data;
        default: ; // unused index
      endcase
    end
  end

  // effective grid and cell size: dims clamped to [2, DIM_CAP], cell 0 taken as 1
  logic [8:0]  eff_rows, eff_cols;
  logic [15:0] eff_cell;

  assign eff_rows = (rows_r < 9'd2) ? 9'd2 : ((rows_r > DIM_CAP) ? DIM_CAP : rows_r);
  assign eff_cols = (cols_r < 9'd2) ? 9'd2 : ((cols_r > DIM_CAP) ? DIM_CAP : cols_r);
  assign eff_cell = (cell_r == 16'd0) ? 16'd1 : cell_r;

  // ---------------------------------------------------------------- store
  logic              mem_we;
  logic [17:0]       wr_addr;
  logic [17:0]       rd_addr;
  logic [HSW-1:0]    rd_data;
  logic signed [16:0] rd_h;

  assign wr_addr = ({10'b0, item_r.vertex_row} * {9'b0, eff_cols})
                 + {10'b0, item_r.vertex_col};
  // writes outside the configured grid are dropped
  assign mem_we  = (state_r == S_WRITE)
                && ({1'b0, item_r.vertex_row} < eff_rows)
                && ({1'b0, item_r.vertex_col} < eff_cols);

  always_comb begin
    case (state_r)
      S_RD_B:  rd_addr = addr_r + 18'd1;
      S_RD_C:  rd_addr = addr_r + {9'b0, eff_cols};
      S_RD_D:  rd_addr = addr_r + {9'b0, eff_cols} + 18'd1;
      default: rd_addr = addr_r;
    endcase
  end

  hts_store #(
    .DEPTH (MAX_DIM * MAX_DIM),
    .AW    (ADDR_W),
    .DW    (HSW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ADDR_W'(wr_addr)),
    .wdata (item_r.vertex_height[HSW-1:0]),
    .raddr (ADDR_W'(rd_addr)),
    .rdata (rd_data)
  );

  assign rd_h = 17'($signed(rd_data));

  // ---------------------------------------------------------------- shared unit
  hts_pkg::unit_req_t unit_req;
  hts_pkg::unit_rsp_t unit_rsp;
  logic signed [26:0] n_mag;

  assign n_mag = n_r[26] ? -n_r : n_r;

  always_comb begin
    unit_req.go     = (state_r == S_DIV_GO) || (state_r == S_MUL1_GO)
                   || (state_r == S_MUL2_GO);
    unit_req.op     = (state_r == S_DIV_GO) ? hts_pkg::UNIT_DIV : hts_pkg::UNIT_MUL;
    unit_req.num    = {n_mag[25:0], 16'b0};
    unit_req.den    = {eff_cell, 1'b0};
    unit_req.mcand  = (state_r == S_MUL2_GO) ? m2_r : m1_r;
    unit_req.mplier = (state_r == S_MUL2_GO) ? d2_r : d1_r;
    unit_req.acc_in = (state_r == S_MUL2_GO) ? unit_rsp.acc : acc0_r;
  end

  hts_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (unit_req),
    .rsp   (unit_rsp)
  );

  // ---------------------------------------------------------------- datapath terms
  logic [24:0]        prod_x, prod_z;
  logic signed [26:0] nx, nz;
  logic signed [42:0] q_mag;
  logic signed [26:0] cq;
  logic [8:0]         lim;
  logic [8:0]         cell9;
  logic signed [42:0] delta;
  logic signed [43:0] dsum;
  logic               upper;
  logic signed [47:0] h_full;
  logic               sat;

  assign prod_x = {16'b0, eff_cols - 9'd1} * {9'b0, eff_cell};
  assign prod_z = {16'b0, eff_rows - 9'd1} * {9'b0, eff_cell};
  // doubled positions are sign-extended to the 27-bit sum
  assign nx = $signed({2'b0, prod_x}) + 27'($signed({item_r.pos_x, 1'b0}));
  assign nz = $signed({2'b0, prod_z}) - 27'($signed({item_r.pos_z, 1'b0}));

  // magnitude quotient as a signed value; S_QFIX takes the floor of the signed quotient
  assign q_mag = $signed({1'b0, unit_rsp.quot});

  // cell = clamp(q >> 16, 0, dim-2); offset keeps its fraction, unbounded outside
  assign cq    = $signed(q_r[42:16]);
  assign lim   = axis_r ? (eff_rows - 9'd2) : (eff_cols - 9'd2);
  assign cell9 = cq[26] ? 9'd0 : ((cq > $signed({18'b0, lim})) ? lim : cq[8:0]);
  assign delta = q_r - $signed({18'b0, cell9, 16'b0});

  assign dsum  = 44'(dx_r) + 44'(dz_r);
  assign upper = (dsum < 44'sd65536);

  assign h_full = unit_rsp.acc[63:16];
  assign sat    = (h_full > 48'sd32767) || (h_full < -48'sd32768);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      axis_r       <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r  <= in_data;
            state_r <= (in_data.command == hts_pkg::CMD_QUERY) ? S_PREP_X : S_WRITE;
          end
        end
        S_WRITE: state_r <= S_IDLE;
        S_PREP_X: begin
          n_r     <= nx;
          axis_r  <= 1'b0;
          state_r <= S_DIV_GO;
        end
        S_PREP_Z: begin
          n_r     <= nz;
          axis_r  <= 1'b1;
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: begin
          neg_r   <= n_r[26];
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (unit_rsp.done) begin
            state_r <= S_QFIX;
          end
        end
        S_QFIX: begin
          q_r     <= neg_r ? -(q_mag + 43'(unit_rsp.rem_nz)) : q_mag;
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          if (axis_r) begin
            row_r   <= cell9;
            dz_r    <= delta;
            state_r <= S_ADDR;
          end else begin
            col_r   <= cell9;
            dx_r    <= delta;
            state_r <= S_PREP_Z;
          end
        end
        S_ADDR: begin
          addr_r  <= ({9'b0, row_r} * {9'b0, eff_cols}) + {9'b0, col_r};
          state_r <= S_RD_A;
        end
        S_RD_A: state_r <= S_RD_B;
        S_RD_B: begin
          a_r     <= rd_h;
          state_r <= S_RD_C;
        end
        S_RD_C: begin
          b_r     <= rd_h;
          state_r <= S_RD_D;
        end
        S_RD_D: begin
          c_r     <= rd_h;
          state_r <= S_RD_END;
        end
        S_RD_END: begin
          d_r     <= rd_h;
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          // upper triangle A,B,C from corner A; lower D,C,B from corner D
          if (upper) begin
            m1_r   <= 45'(dx_r);
            m2_r   <= 45'(dz_r);
            d1_r   <= b_r - a_r;
            d2_r   <= c_r - a_r;
            acc0_r <= (64'(a_r) <<< 16) + 64'sd32768;
          end else begin
            m1_r   <= 45'sd65536 - 45'(dx_r);
            m2_r   <= 45'sd65536 - 45'(dz_r);
            d1_r   <= c_r - d_r;
            d2_r   <= b_r - d_r;
            acc0_r <= (64'(d_r) <<< 16) + 64'sd32768;
          end
          state_r <= S_MUL1_GO;
        end
        S_MUL1_GO: state_r <= S_MUL1_WAIT;
        S_MUL1_WAIT: begin
          if (unit_rsp.done) begin
            state_r <= S_MUL2_GO;
          end
        end
        S_MUL2_GO: state_r <= S_MUL2_WAIT;
        S_MUL2_WAIT: begin
          if (unit_rsp.done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // half-up rounding was folded into the accumulator start value
          out_data_r.saturated  <= sat;
          out_data_r.height_out <= !sat ? h_full[15:0]
                                 : (h_full[47] ? 16'sh8000 : 16'sh7fff);
          out_strobe_r <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

FILE: design/hts_store.sv
// Height store: one write port, one registered read port
module hts_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/hts_unit.sv
// Shared iterative unit: restoring divide and shift-add multiply-accumulate on one adder
module hts_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  hts_pkg::unit_req_t  req,
  output hts_pkg::unit_rsp_t  rsp
);

  logic                busy_r;
  logic                done_r;
  hts_pkg::unit_op_t   op_r;
  logic [5:0]          cnt_r;
  logic [63:0]         acc_r;
  logic [41:0]         q_r;
  logic [63:0]         mc_r;
  logic [16:0]         mp_r;
  logic [16:0]         den_r;

  logic [63:0] add_a;
  logic [63:0] add_b;
  logic        add_sub;
  logic [63:0] add_sum;
  logic [17:0] rem_sh;
  logic        last;

  assign rem_sh = {acc_r[16:0], q_r[41]};

  always_comb begin
    if (op_r == hts_pkg::UNIT_DIV) begin
      add_a   = {46'b0, rem_sh};
      add_b   = {47'b0, den_r};
      add_sub = 1'b1;
    end else begin
      add_a   = acc_r;
      add_b   = mc_r;
      add_sub = (cnt_r == hts_pkg::MUL_LAST); // top multiplier bit weighs negative
    end
    add_sum = add_a + (add_b ^ {64{add_sub}}) + {63'b0, add_sub};
  end

  assign last = (op_r == hts_pkg::UNIT_DIV) ? (cnt_r == hts_pkg::DIV_LAST)
                                            : (cnt_r == hts_pkg::MUL_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
        op_r   <= req.op;
        acc_r  <= (req.op == hts_pkg::UNIT_DIV) ? 64'd0 : req.acc_in;
        q_r    <= req.num;
        den_r  <= req.den;
        mc_r   <= 64'(req.mcand);
        mp_r   <= req.mplier;
      end else if (busy_r) begin
        if (op_r == hts_pkg::UNIT_DIV) begin
          acc_r <= add_sum[63] ? {46'b0, rem_sh} : add_sum;
          q_r   <= {q_r[40:0], ~add_sum[63]};
        end else begin
          if (mp_r[0]) begin
            acc_r <= add_sum;
          end
          mc_r <= {mc_r[62:0], 1'b0};
          mp_r <= {1'b0, mp_r[16:1]};
        end
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 6'd1;
        end
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.quot   = q_r;
  assign rsp.rem_nz = |acc_r[16:0];
  assign rsp.acc    = acc_r;

endmodule

FILE: design/hts_checker.sv
// Port-level checker for the heightmap triangle height sampler, with its bind
`include "heightmap_triangle_height_sampler_assert.svh"

module hts_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         start,
  input logic         busy,
  input hts_pkg::in_t in_data,
  input logic         out_strobe,
  input logic         cfg_valid,
  input logic         cfg_ready
);

  `HTS_CHK_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `HTS_CHK_NOW(a_strobe_idle, out_strobe, !busy, "result strobe while still busy")
  `HTS_CHK_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe held two cycles")
  `HTS_CHK_NEXT(a_write_silent, start && !busy && (in_data.command == hts_pkg::CMD_WRITE), !out_strobe ##1 !out_strobe, "write beat produced a result")
  `HTS_CHK_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind heightmap_triangle_height_sampler hts_checker u_hts_checker (.*);

FILE: tb/hts_height_checker.sv
// Checker for the heightmap sampler: watches all channels, predicts each height, compares
module hts_height_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  hts_pkg::in_t  in_data,
  input  logic          out_strobe,
  input  hts_pkg::out_t out_data,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output int            pending,
  output int            fails
);

  logic [8:0]         rows_q, cols_q;
  logic [15:0]        cell_q;
  logic signed [15:0] hstore [0:65535];
  hts_pkg::out_t      height_queue [$];

  initial begin
    pending = 0;
    fails   = 0;
  end

  function automatic int dim_clamp(logic [8:0] v);
    if (v < 2) return 2;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  // clamped cell and Q.16 offset along one axis
  function automatic void place(longint n, longint two_s, int dim,
                                output longint cidx, output longint frac);
    longint q;
    q = fdiv(n, two_s);
    if (q < 0) q = 0;
    if (q > dim - 2) q = dim - 2;
    cidx = q;
    frac = fdiv((n - two_s * q) * 65536, two_s);
  endfunction

  function automatic hts_pkg::out_t sample_height(hts_pkg::in_t d);
    int            nr, nc;
    longint        s, two_s, nx, nz, col, row, dx, dz, a, b, cv, dd, sum, h;
    hts_pkg::out_t o;
    nr = dim_clamp(rows_q);
    nc = dim_clamp(cols_q);
    s = (cell_q == 0) ? 1 : longint'(cell_q);
    two_s = 2 * s;
    nx = longint'(nc - 1) * s + 2 * longint'(d.pos_x);
    nz = longint'(nr - 1) * s - 2 * longint'(d.pos_z);
    place(nx, two_s, nc, col, dx);
    place(nz, two_s, nr, row, dz);
    a  = longint'(hstore[row * nc + col]);
    b  = longint'(hstore[row * nc + col + 1]);
    cv = longint'(hstore[(row + 1) * nc + col]);
    dd = longint'(hstore[(row + 1) * nc + col + 1]);
    if (dx + dz < 65536)
      sum = a * 65536 + (b - a) * dx + (cv - a) * dz;
    else
      sum = dd * 65536 + (cv - dd) * (65536 - dx) + (b - dd) * (65536 - dz);
    h = fdiv(sum + 32768, 65536);
    o.saturated = 1'b0;
    if (h > 32767) begin
      h = 32767;
      o.saturated = 1'b1;
    end
    if (h < -32768) begin
      h = -32768;
      o.saturated = 1'b1;
    end
    o.height_out = h[15:0];
    return o;
  endfunction

  always @(posedge clk) begin
    int            nerr;
    hts_pkg::out_t exp_o;
    nerr = 0;
    if (!rst_n) begin
      rows_q <= 9'd256;
      cols_q <= 9'd256;
      cell_q <= 16'd256;
      height_queue.delete();
    end else begin
      if (out_strobe) begin
        if (height_queue.size() == 0) begin
          $display("%0t unexpected result: expected none, got height %0d sat %0b",
                   $time, out_data.height_out, out_data.saturated);
          nerr++;
        end else begin
          exp_o = height_queue.pop_front();
          if (out_data.height_out !== exp_o.height_out) begin
            $display("%0t height_out: expected %0d, got %0d",
                     $time, exp_o.height_out, out_data.height_out);
            nerr++;
          end
          if (out_data.saturated !== exp_o.saturated) begin
            $display("%0t saturated: expected %0b, got %0b",
                     $time, exp_o.saturated, out_data.saturated);
            nerr++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hts_pkg::CFG_ROWS: rows_q <= cfg_data[8:0];
          hts_pkg::CFG_COLS: cols_q <= cfg_data[8:0];
          hts_pkg::CFG_CELL: cell_q <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_data.command == hts_pkg::CMD_WRITE) begin
          if (in_data.vertex_row < dim_clamp(rows_q) && in_data.vertex_col < dim_clamp(cols_q))
            hstore[int'(in_data.vertex_row) * dim_clamp(cols_q) + int'(in_data.vertex_col)]
              <= in_data.vertex_height;
        end else begin
          height_queue.push_back(sample_height(in_data));
        end
      end
    end
    pending <= height_queue.size();
    fails   <= fails + nerr;
  end
endmodule

FILE: tb/tb_heightmap_triangle_height_sampler.sv
// Testbench top for the heightmap sampler: clock, reset, stimulus and verdict
module tb_heightmap_triangle_height_sampler;

  localparam int STALL_LIMIT = 4000; // cycles with no beat anywhere
  localparam int TAIL_WAIT   = 200;  // cycles waited once all results are back
  localparam int PHASE_BEATS = 112;  // input beats per random phase, fills included

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  hts_pkg::in_t  in_data = '0;
  logic          out_strobe;
  hts_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = hts_pkg::CFG_ROWS;
  logic [15:0]   cfg_data = '0;
  int            pending, fails;

  // mirror of the programmed grid, so queries only touch written entries
  int g_rows = 256, g_cols = 256, g_cell = 256;
  bit wr_done [0:65535];
  bit idle_on = 1'b1;
  int stall_cnt = 0;
  int n_sent = 0;

  int phase_rows [8] = '{2, 0, 511, 256, 4, 256, 3, 0};
  int phase_cols [8] = '{2, 1, 3, 256, 7, 256, 256, 0};
  int phase_cell [8] = '{1, 0, 65535, 65535, 300, 1, 2048, 0};

  always #10 clk = ~clk;

  heightmap_triangle_height_sampler i_dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_strobe, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  hts_height_checker i_chk (
    .clk, .rst_n, .start, .busy, .in_data, .out_strobe, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .pending, .fails
  );

  // watchdog: any beat on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || out_strobe) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t watchdog expired", $time);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  // clamped cell index along one axis for the current grid
  function automatic int cell_at(longint n, int dim);
    longint q;
    q = fdiv(n, 2 * longint'(g_cell));
    if (q < 0) q = 0;
    if (q > dim - 2) q = dim - 2;
    return int'(q);
  endfunction

  function automatic logic signed [15:0] rand_height();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 512)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly inside the grid, some past the edges, some anywhere in range
  function automatic logic signed [23:0] pick_pos(int dim);
    longint span, v;
    int     mode;
    span = longint'(dim - 1) * g_cell;
    mode = $urandom_range(0, 9);
    if (mode < 6)      v = longint'($urandom_range(0, 32'(span))) - span / 2;
    else if (mode < 8) v = (span / 2 + $urandom_range(0, 200000)) * (mode == 6 ? -1 : 1);
    else               v = longint'(signed'(24'($urandom)));
    if (v > 8388607)  v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  // one beat; start stays high afterwards unless an idle burst follows
  task automatic send_beat(hts_pkg::in_t d);
    bit took;
    start   <= 1'b1;
    in_data <= d;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    n_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic write_height(int r, int c, logic signed [15:0] h);
    hts_pkg::in_t d;
    d = '0;
    d.command       = hts_pkg::CMD_WRITE;
    d.vertex_row    = r[7:0];
    d.vertex_col    = c[7:0];
    d.vertex_height = h;
    d.pos_x         = 24'($urandom);
    d.pos_z         = 24'($urandom);
    if (r < g_rows && c < g_cols) wr_done[r * g_cols + c] = 1'b1;
    send_beat(d);
  endtask

  // fills any unwritten corner of the target cell, then queries
  task automatic query_at(logic signed [23:0] px, logic signed [23:0] pz);
    int           col, row;
    hts_pkg::in_t d;
    col = cell_at(longint'(g_cols - 1) * g_cell + 2 * longint'(px), g_cols);
    row = cell_at(longint'(g_rows - 1) * g_cell - 2 * longint'(pz), g_rows);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        if (!wr_done[(row + i) * g_cols + col + j])
          write_height(row + i, col + j, rand_height());
    d = hts_pkg::in_t'($bits(hts_pkg::in_t)'({$urandom, $urandom, $urandom}));
    d.command = hts_pkg::CMD_QUERY;
    d.pos_x   = px;
    d.pos_z   = pz;
    send_beat(d);
  endtask

  // waits until the block is quiet: all results in, then write tail, then not busy
  task automatic wait_quiet();
    bit idle_now;
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    do begin
      @(negedge clk);
      idle_now = !busy;
      @(posedge clk);
    end while (!idle_now);
  endtask

  // valid drops for one cycle after each beat
  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int dim_eff(int v);
    return v < 2 ? 2 : (v > 256 ? 256 : v);
  endfunction

  task automatic set_grid(int r, int c, int s);
    cfg_write(hts_pkg::CFG_ROWS, 16'(r));
    cfg_write(hts_pkg::CFG_COLS, 16'(c));
    cfg_write(hts_pkg::CFG_CELL, 16'(s));
    g_rows = dim_eff(r);
    g_cols = dim_eff(c);
    g_cell = (s == 0) ? 1 : s;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset grid 256x256 at unit cell size:
    // steep corner slopes so extrapolation far outside clips both ways
    write_height(0, 0, 16'sh7FFF);
    write_height(0, 1, 16'sh8000);
    write_height(1, 0, 16'sh8000);
    write_height(1, 1, 16'sh7FFF);
    write_height(255, 255, 16'sh7FFF);
    write_height(255, 254, 16'sh8000);
    write_height(254, 255, 16'sh8000);
    write_height(254, 254, 16'sh0000);
    write_height(300 - 256, 255, 16'sh0100);   // in grid, last column
    query_at(24'sh800000, 24'sh7FFFFF);        // far corner beyond row 0 / col 0
    query_at(24'sh7FFFFF, 24'sh800000);        // far corner beyond the last cell
    query_at(24'sh800000, 24'sh800000);
    query_at(24'sh7FFFFF, 24'sh7FFFFF);
    query_at(-24'sd32640, 24'sd32640);         // exactly on vertex (0,0)
    query_at(-24'sd32512, 24'sd32512);         // centre of cell (0,0), on the diagonal
    query_at(-24'sd32600, 24'sd32520);         // upper triangle
    query_at(-24'sd32530, 24'sd32600);         // upper triangle as well
    query_at(24'sd0, 24'sd0);
    wait_quiet();

    // out-of-range index is a no-op; grid writes beyond the rows are ignored
    cfg_write(2'd3, 16'hFFFF);
    set_grid(2, 2, 1);
    write_height(255, 255, 16'sh1234);
    write_height(2, 0, 16'sh4321);
    query_at(24'sd0, 24'sd0);
    wait_quiet();

    // random phases through several grid settings, the extremes among them
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) set_grid($urandom_range(2, 256), $urandom_range(2, 256),
                            $urandom_range(1, 65535));
      else set_grid(phase_rows[ph], phase_cols[ph], phase_cell[ph]);
      while (n_sent < PHASE_BEATS * (ph + 1)) begin
        idle_on = (n_sent < 760);
        if ($urandom_range(0, 3) == 0)
          write_height($urandom_range(0, 255), $urandom_range(0, 255), rand_height());
        else
          query_at(pick_pos(g_cols), pick_pos(g_rows));
      end
      // sender holds off until every result of the phase is back
      wait_quiet();
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_WAIT) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
